/* rtl/i2cm_pkg.sv */
// Shared types for the I2C master byte engine: command kinds, the decoded
// item that crosses the queue, and the result record. No dependencies.
package i2cm_pkg;

    // Command kinds as they arrive on the input channel
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_READ  = 3'd3,
        KIND_STOP  = 3'd4
    } kind_t;

    // Decoded item handed from the front end to the bit engine
    typedef struct packed {
        logic       is_cmd;
        kind_t      cmd;
        logic [7:0] load_byte;
        logic       send_ack;
        logic       scl_sense;
        logic       sda_sense;
    } item_t;

    // One result item
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       ack_missing;
        logic [7:0] read_byte;
        logic       refused;
    } res_t;

    localparam int unsigned ITEM_W = $bits(item_t);

endpackage

/* rtl/i2cm_front.sv */
// Front end of the I2C master byte engine: accepts input items and decodes
// them into queue entries. Depends on i2cm_pkg.
module i2cm_front (
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_kind,
    input  logic [6:0]          s_address,
    input  logic                s_read_not_write,
    input  logic [7:0]          s_write_byte,
    input  logic                s_send_ack,
    input  logic                s_scl_sense,
    input  logic                s_sda_sense,
    output logic                push_valid,
    input  logic                push_ready,
    output i2cm_pkg::item_t     push_item
);

    logic is_cmd;

    // Flag real commands; kinds above stop count as plain ticks
    always_comb begin
        is_cmd = (s_kind inside {i2cm_pkg::KIND_START, i2cm_pkg::KIND_WRITE,
                                 i2cm_pkg::KIND_READ, i2cm_pkg::KIND_STOP});
    end

    // Build the queue entry, preparing the byte the engine will shift
    always_comb begin
        push_item.is_cmd    = is_cmd;
        push_item.cmd       = is_cmd ? i2cm_pkg::kind_t'(s_kind) : i2cm_pkg::KIND_TICK;
        push_item.send_ack  = s_send_ack;
        push_item.scl_sense = s_scl_sense;
        push_item.sda_sense = s_sda_sense;
        case (push_item.cmd)
            i2cm_pkg::KIND_START: push_item.load_byte = {s_address, s_read_not_write};
            i2cm_pkg::KIND_WRITE: push_item.load_byte = s_write_byte;
            default:              push_item.load_byte = 8'h00;
        endcase
    end

    // Pass the handshake straight to the queue; hold nothing while in reset
    assign push_valid = s_valid & aresetn;
    assign s_ready    = push_ready & aresetn;

endmodule

/* rtl/i2cm_queue.sv */
// Short register queue between the front end and the bit engine.
// Generic over width and depth; no package dependency.
module i2cm_queue #(
    parameter int unsigned WIDTH = 15,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry; storage needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/i2cm_engine.sv */
// Back end of the I2C master byte engine: the half-bit state machine and
// the result output register. Depends on i2cm_pkg.
module i2cm_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  i2cm_pkg::item_t    pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output i2cm_pkg::res_t     m_res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_REL,
        PH_ST_WAIT,
        PH_ST_SCL,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_BIT_WAIT,
        PH_SP_HIGH,
        PH_SP_WAIT
    } phase_t;

    phase_t              phase_reg, phase_next;
    i2cm_pkg::kind_t     cmd_reg, cmd_next;
    logic [3:0]          bit_count_reg, bit_count_next;
    logic [7:0]          shift_reg, shift_next;
    logic                ack_choice_reg, ack_choice_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                out_valid_reg, out_valid_next;
    i2cm_pkg::res_t      out_reg, out_next;
    logic                take;
    logic                bits_left;

    // Take the next item whenever the output slot is free or being drained
    assign pop_ready = !out_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign bits_left = !bit_count_reg[3];
    assign m_valid   = out_valid_reg;
    assign m_res     = out_reg;

    // Step the engine by one half-bit tick
    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (take) begin
            out_next.done_res    = 1'b0;
            out_next.ack_missing = 1'b0;
            out_next.read_byte   = 8'h00;
            out_next.refused     = 1'b0;

            if (phase_reg == PH_IDLE) begin
                // Launch a new command
                if (pop_item.is_cmd) begin
                    cmd_next       = pop_item.cmd;
                    bit_count_next = 4'd0;
                    case (pop_item.cmd)
                        i2cm_pkg::KIND_START: begin
                            shift_next = pop_item.load_byte;
                            sda_next   = 1'b0;
                            phase_next = PH_ST_REL;
                        end
                        i2cm_pkg::KIND_WRITE: begin
                            shift_next = pop_item.load_byte;
                            scl_next   = 1'b1;
                            phase_next = PH_BIT_LOW;
                        end
                        i2cm_pkg::KIND_READ: begin
                            shift_next      = 8'h00;
                            ack_choice_next = pop_item.send_ack;
                            scl_next        = 1'b1;
                            sda_next        = 1'b0;
                            phase_next      = PH_BIT_LOW;
                        end
                        i2cm_pkg::KIND_STOP: begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_SP_HIGH;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end else begin
                // Drop any command that arrives mid-transfer
                out_next.refused = pop_item.is_cmd;
                case (phase_reg)
                    PH_ST_REL: begin
                        scl_next   = 1'b0;
                        phase_next = PH_ST_WAIT;
                    end
                    PH_ST_WAIT: begin
                        if (pop_item.scl_sense) begin
                            sda_next   = 1'b1;
                            phase_next = PH_ST_SCL;
                        end
                    end
                    PH_ST_SCL: begin
                        scl_next   = 1'b1;
                        phase_next = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        if (cmd_reg == i2cm_pkg::KIND_READ) begin
                            sda_next = bits_left ? 1'b0 : ack_choice_reg;
                        end else begin
                            sda_next = bits_left ? !shift_reg[7] : 1'b0;
                        end
                        phase_next = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_BIT_WAIT;
                    end
                    PH_BIT_WAIT: begin
                        // Hold while the target stretches the clock
                        if (pop_item.scl_sense) begin
                            if (bits_left) begin
                                if (cmd_reg == i2cm_pkg::KIND_READ) begin
                                    shift_next = {shift_reg[6:0], pop_item.sda_sense};
                                end else begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                end
                                bit_count_next = bit_count_reg + 4'd1;
                                scl_next       = 1'b1;
                                phase_next     = PH_BIT_LOW;
                            end else begin
                                out_next.done_res = 1'b1;
                                phase_next        = PH_IDLE;
                                sda_next          = 1'b0;
                                if (cmd_reg == i2cm_pkg::KIND_READ) begin
                                    scl_next           = 1'b1;
                                    out_next.read_byte = shift_reg;
                                end else if (pop_item.sda_sense) begin
                                    out_next.ack_missing = 1'b1;
                                end else begin
                                    scl_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_SP_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_SP_WAIT;
                    end
                    PH_SP_WAIT: begin
                        if (pop_item.scl_sense) begin
                            sda_next          = 1'b0;
                            out_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            out_next.scl_pull_low = scl_next;
            out_next.sda_pull_low = sda_next;
            out_next.busy_res     = (phase_next != PH_IDLE);
            out_valid_next        = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold engine state and the registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= i2cm_pkg::KIND_TICK;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'h00;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end else begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

/* rtl/i2c_master_byte_engine_top.sv */
// I2C master byte engine, one half-bit tick per item, one result per item.
// Each accepted item waits in the queue until the engine takes it and registers its
// result. Throughput: one item per cycle while m_ready drains the output slot, set
// by the state update of the bit engine.
// Reset: synchronous active-low aresetn empties the queue and output slot,
// returns the engine to idle and releases both lines.
module i2c_master_byte_engine_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  logic [6:0] s_address,
    input  logic       s_read_not_write,
    input  logic [7:0] s_write_byte,
    input  logic       s_send_ack,
    input  logic       s_scl_sense,
    input  logic       s_sda_sense,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_pull_low,
    output logic       m_sda_pull_low,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic       m_ack_missing,
    output logic [7:0] m_read_byte,
    output logic       m_refused
);

    logic                        push_valid, push_ready;
    i2cm_pkg::item_t             push_item;
    logic                        pop_valid, pop_ready;
    logic [i2cm_pkg::ITEM_W-1:0] pop_data;
    i2cm_pkg::item_t             pop_item;
    i2cm_pkg::res_t              res;

    // Accept and decode
    i2cm_front u_front (
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_address        (s_address),
        .s_read_not_write (s_read_not_write),
        .s_write_byte     (s_write_byte),
        .s_send_ack       (s_send_ack),
        .s_scl_sense      (s_scl_sense),
        .s_sda_sense      (s_sda_sense),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    // Decouple front and engine
    i2cm_queue #(
        .WIDTH (i2cm_pkg::ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_item = i2cm_pkg::item_t'(pop_data);

    // Run the bus sequences
    i2cm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_scl_pull_low = res.scl_pull_low;
    assign m_sda_pull_low = res.sda_pull_low;
    assign m_busy_res     = res.busy_res;
    assign m_done_res     = res.done_res;
    assign m_ack_missing  = res.ack_missing;
    assign m_read_byte    = res.read_byte;
    assign m_refused      = res.refused;

endmodule

/* sim/i2c_master_byte_engine_top_test.sv */
// Self-checking testbench for i2c_master_byte_engine_top: a short table of bus ticks,
// then random command traffic, each result checked against a table entry or a bit-level model of the engine.
// Depends on rtl/i2cm_pkg.sv and rtl/i2c_master_byte_engine_top.sv.
module i2c_master_byte_engine_top_test;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned PAUSE_AT     = 300;
    localparam int unsigned HOLD_AFTER   = 200;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RUN_LIMIT    = 1_000_000;

    // Kinds the engine treats as a plain tick
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    // Bus sequencer steps of the model engine
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_REL, SEQ_START_WAIT, SEQ_START_SCL,
        SEQ_BIT_SET, SEQ_BIT_RISE, SEQ_BIT_WAIT, SEQ_STOP_RISE, SEQ_STOP_WAIT
    } seq_t;

    typedef struct packed {
        logic [2:0]     kind;
        logic [6:0]     address;
        logic           rnw;
        logic [7:0]     wbyte;
        logic           sack;
        logic           scl;
        logic           sda;
        logic           typed;
        i2cm_pkg::res_t want;
    } tick_row_t;

    localparam i2cm_pkg::res_t RES_QUIET  = '0;
    localparam i2cm_pkg::res_t RES_STOP_1 = '{scl_pull_low: 1'b1, sda_pull_low: 1'b1,
                                              busy_res: 1'b1, default: '0};

    // Directed ticks: spare kinds at idle, a stop with stretching and a refused start,
    // then a start with stretching and refused commands, into the first address bits
    localparam int unsigned N_ROWS = 25;
    localparam tick_row_t TICK_ROWS [N_ROWS] = '{
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, RES_QUIET},
        '{KIND_SPARE_LO,        7'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, RES_QUIET},
        '{KIND_SPARE_HI,        7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, RES_QUIET},
        '{KIND_SPARE_MID,       7'h55, 1'b0, 8'hAA, 1'b0, 1'b0, 1'b1, 1'b1, RES_QUIET},
        '{i2cm_pkg::KIND_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, RES_STOP_1},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_START, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_START, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_READ,  7'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RES_QUIET},
        '{i2cm_pkg::KIND_TICK,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_kind = i2cm_pkg::KIND_TICK;
    logic [6:0] s_address = '0;
    logic       s_read_not_write = 1'b0;
    logic [7:0] s_write_byte = '0;
    logic       s_send_ack = 1'b0;
    logic       s_scl_sense = 1'b1;
    logic       s_sda_sense = 1'b1;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_scl_pull_low;
    logic       m_sda_pull_low;
    logic       m_busy_res;
    logic       m_done_res;
    logic       m_ack_missing;
    logic [7:0] m_read_byte;
    logic       m_refused;

    // Model engine state
    seq_t            seq;
    i2cm_pkg::kind_t active_cmd;
    logic [3:0]      bit_cnt;
    logic [7:0]      shift_reg;
    logic            ack_sel;
    logic            scl_drv;
    logic            sda_drv;

    i2cm_pkg::res_t pending_results[$];
    int unsigned    mismatches = 0;
    int unsigned    results_seen = 0;
    bit             no_idle = 1'b0;

    always #1 aclk = ~aclk;

    i2c_master_byte_engine_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_address        (s_address),
        .s_read_not_write (s_read_not_write),
        .s_write_byte     (s_write_byte),
        .s_send_ack       (s_send_ack),
        .s_scl_sense      (s_scl_sense),
        .s_sda_sense      (s_sda_sense),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_scl_pull_low   (m_scl_pull_low),
        .m_sda_pull_low   (m_sda_pull_low),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .m_ack_missing    (m_ack_missing),
        .m_read_byte      (m_read_byte),
        .m_refused        (m_refused)
    );

    // Advance the model engine by one half-bit tick and return the line result
    function automatic i2cm_pkg::res_t predict_line_result(input logic [2:0] kind,
                                                 input logic [6:0] addr,
                                                 input logic rnw, input logic [7:0] wbyte,
                                                 input logic sack, input logic scl_in,
                                                 input logic sda_in);
        i2cm_pkg::res_t r;
        logic is_cmd;
        r = '0;
        is_cmd = (kind >= i2cm_pkg::KIND_START) && (kind <= i2cm_pkg::KIND_STOP);
        if (seq == SEQ_IDLE) begin
            if (is_cmd) begin
                active_cmd = i2cm_pkg::kind_t'(kind);
                bit_cnt = '0;
                case (kind)
                    i2cm_pkg::KIND_START: begin
                        shift_reg = {addr, rnw};
                        sda_drv = 1'b0;
                        seq = SEQ_START_REL;
                    end
                    i2cm_pkg::KIND_WRITE: begin
                        shift_reg = wbyte;
                        scl_drv = 1'b1;
                        seq = SEQ_BIT_SET;
                    end
                    i2cm_pkg::KIND_READ: begin
                        shift_reg = '0;
                        ack_sel = sack;
                        scl_drv = 1'b1;
                        sda_drv = 1'b0;
                        seq = SEQ_BIT_SET;
                    end
                    default: begin
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        seq = SEQ_STOP_RISE;
                    end
                endcase
            end
        end else begin
            r.refused = is_cmd;
            case (seq)
                SEQ_START_REL: begin
                    scl_drv = 1'b0;
                    seq = SEQ_START_WAIT;
                end
                SEQ_START_WAIT: begin
                    if (scl_in) begin
                        sda_drv = 1'b1;
                        seq = SEQ_START_SCL;
                    end
                end
                SEQ_START_SCL: begin
                    scl_drv = 1'b1;
                    seq = SEQ_BIT_SET;
                end
                SEQ_BIT_SET: begin
                    // Write data bits put the MSB on SDA, read data bits release it; the ninth slot is the acknowledge
                    if (active_cmd == i2cm_pkg::KIND_READ)
                        sda_drv = (bit_cnt < 4'd8) ? 1'b0 : ack_sel;
                    else
                        sda_drv = (bit_cnt < 4'd8) ? ~shift_reg[7] : 1'b0;
                    seq = SEQ_BIT_RISE;
                end
                SEQ_BIT_RISE: begin
                    scl_drv = 1'b0;
                    seq = SEQ_BIT_WAIT;
                end
                SEQ_BIT_WAIT: begin
                    // Hold while the target stretches the clock
                    if (scl_in) begin
                        if (bit_cnt < 4'd8) begin
                            if (active_cmd == i2cm_pkg::KIND_READ)
                                shift_reg = {shift_reg[6:0], sda_in};
                            else
                                shift_reg = {shift_reg[6:0], 1'b0};
                            bit_cnt = bit_cnt + 4'd1;
                            scl_drv = 1'b1;
                            seq = SEQ_BIT_SET;
                        end else begin
                            r.done_res = 1'b1;
                            seq = SEQ_IDLE;
                            sda_drv = 1'b0;
                            if (active_cmd == i2cm_pkg::KIND_READ) begin
                                scl_drv = 1'b1;
                                r.read_byte = shift_reg;
                            end else if (sda_in) begin
                                r.ack_missing = 1'b1;
                            end else begin
                                scl_drv = 1'b1;
                            end
                        end
                    end
                end
                SEQ_STOP_RISE: begin
                    scl_drv = 1'b0;
                    seq = SEQ_STOP_WAIT;
                end
                SEQ_STOP_WAIT: begin
                    if (scl_in) begin
                        sda_drv = 1'b0;
                        r.done_res = 1'b1;
                        seq = SEQ_IDLE;
                    end
                end
                default: seq = SEQ_IDLE;
            endcase
        end
        r.scl_pull_low = scl_drv;
        r.sda_pull_low = sda_drv;
        r.busy_res = (seq != SEQ_IDLE);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_item(input logic [2:0] kind, input logic [6:0] addr, input logic rnw,
                             input logic [7:0] wbyte, input logic sack, input logic scl,
                             input logic sda, input logic typed, input i2cm_pkg::res_t want);
        int unsigned gap;
        i2cm_pkg::res_t got;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_kind <= kind;
        s_address <= addr;
        s_read_not_write <= rnw;
        s_write_byte <= wbyte;
        s_send_ack <= sack;
        s_scl_sense <= scl;
        s_sda_sense <= sda;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        got = predict_line_result(kind, addr, rnw, wbyte, sack, scl, sda);
        pending_results.push_back(typed ? want : got);
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin : result_check
        i2cm_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result expected none, actual scl %0b sda %0b", $time,
                         m_scl_pull_low, m_sda_pull_low);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("scl_pull_low", 32'(want.scl_pull_low), 32'(m_scl_pull_low));
                check_field("sda_pull_low", 32'(want.sda_pull_low), 32'(m_sda_pull_low));
                check_field("busy_res", 32'(want.busy_res), 32'(m_busy_res));
                check_field("done_res", 32'(want.done_res), 32'(m_done_res));
                check_field("ack_missing", 32'(want.ack_missing), 32'(m_ack_missing));
                check_field("read_byte", 32'(want.read_byte), 32'(m_read_byte));
                check_field("refused", 32'(want.refused), 32'(m_refused));
            end
            results_seen++;
        end
    end

    // Drive result-side ready: random stalls, plus one long hold that backs up the input
    initial begin : result_ready
        int unsigned stall;
        bit held;
        stall = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                stall = no_idle ? 0 : pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    stall--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Reset, directed ticks, random command traffic, then drain
    initial begin : stimulus
        int unsigned n;
        int unsigned r;
        logic [2:0] kind;
        seq = SEQ_IDLE;
        active_cmd = i2cm_pkg::KIND_TICK;
        bit_cnt = '0;
        shift_reg = '0;
        ack_sel = 1'b0;
        scl_drv = 1'b0;
        sda_drv = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < N_ROWS; n++) begin
            send_item(TICK_ROWS[n].kind, TICK_ROWS[n].address, TICK_ROWS[n].rnw,
                      TICK_ROWS[n].wbyte, TICK_ROWS[n].sack, TICK_ROWS[n].scl,
                      TICK_ROWS[n].sda, TICK_ROWS[n].typed, TICK_ROWS[n].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // Let every expected result come home before going on
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            r = $urandom_range(0, 99);
            if (seq == SEQ_IDLE) begin
                if (r < 20)
                    kind = i2cm_pkg::KIND_START;
                else if (r < 45)
                    kind = i2cm_pkg::KIND_WRITE;
                else if (r < 70)
                    kind = i2cm_pkg::KIND_READ;
                else if (r < 85)
                    kind = i2cm_pkg::KIND_STOP;
                else if (r < 90)
                    kind = i2cm_pkg::KIND_TICK;
                else
                    kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end else begin
                if (r < 88)
                    kind = i2cm_pkg::KIND_TICK;
                else if (r < 94)
                    kind = 3'($urandom_range(i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP));
                else
                    kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
            // Mostly a high SCL, with occasional stretching by the target
            send_item(kind, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 99) < 80), 1'($urandom_range(0, 1)), 1'b0,
                      RES_QUIET);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial begin : run_limit
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
